// ===== hdl/lzw_variable_width_decoder_defines.svh =====
// Assertion macros for the checker file of the LZW decoder.
`ifndef LZW_VARIABLE_WIDTH_DECODER_DEFINES_SVH
`define LZW_VARIABLE_WIDTH_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define LVWD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lvwd checker: property failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define LVWD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lvwd checker: property failed");

`endif

// ===== hdl/lvwd_pkg.sv =====
`timescale 1ns / 1ps
package lvwd_pkg;

  localparam int DICT_ENTRIES = 512;
  localparam int BASE_CODES   = 256;
  localparam int STACK_DEPTH  = 257;

  // One classified code handed from the front end to the back end.
  typedef struct packed {
    logic [8:0] code;
    logic       bad;
    logic       resolve;
    logic [7:0] res_idx;
    logic       add;
    logic [7:0] new_idx;
  } code_item_t;

  // Queue status seen by the front end and the back end.
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_LOOKUP  = 8'b0000_0010,
    ST_RESOLVE = 8'b0000_0100,
    ST_WSTART  = 8'b0000_1000,
    ST_WALK    = 8'b0001_0000,
    ST_EREAD   = 8'b0010_0000,
    ST_ECAP    = 8'b0100_0000,
    ST_EOUT    = 8'b1000_0000
  } back_state_t;

endpackage

// ===== hdl/lvwd_ram.sv =====
`timescale 1ns / 1ps
module lvwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/lvwd_front.sv =====
`timescale 1ns / 1ps
module lvwd_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   in_new,
  input  lvwd_pkg::q_status_t    q_stat,
  output logic                   push,
  output lvwd_pkg::code_item_t   push_item
);

  logic [9:0]  cnt_r, cnt_nxt, cnt_b;
  logic [3:0]  width_r, width_nxt, width_b;
  logic [15:0] buf_r, buf_nxt, buf_b;
  logic [4:0]  bc_r, bc_nxt, bc_b;
  logic        unres_r, unres_nxt, unres_b;

  logic [15:0] cat, shifted, wmask, rmask;
  logic [4:0]  bc_cat, bc2;
  logic [8:0]  code;
  logic        have_code, bad, add, accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    // A new stream restarts from the reset state before this byte.
    cnt_b   = in_new ? 10'(lvwd_pkg::BASE_CODES) : cnt_r;
    width_b = in_new ? 4'd8 : width_r;
    buf_b   = in_new ? 16'd0 : buf_r;
    bc_b    = in_new ? 5'd0 : bc_r;
    unres_b = in_new ? 1'b0 : unres_r;

    cat       = {buf_b[7:0], in_byte};
    bc_cat    = bc_b + 5'd8;
    have_code = bc_cat >= {1'b0, width_b};
    bc2       = bc_cat - {1'b0, width_b};
    shifted   = cat >> bc2;
    wmask     = (16'(1) << width_b) - 16'd1;
    rmask     = (16'(1) << bc2) - 16'd1;
    code      = 9'(shifted & wmask);
    bad       = {1'b0, code} >= cnt_b;
    add       = cnt_b < 10'(lvwd_pkg::DICT_ENTRIES);

    push_item.code    = code;
    push_item.bad     = bad;
    push_item.resolve = unres_b;
    push_item.res_idx = 8'(cnt_b - 10'd1);
    push_item.add     = add;
    push_item.new_idx = cnt_b[7:0];
    push              = accept && have_code;

    cnt_nxt   = cnt_b;
    width_nxt = width_b;
    unres_nxt = unres_b;
    buf_nxt   = have_code ? (cat & rmask) : cat;
    bc_nxt    = have_code ? bc2 : bc_cat;
    if (have_code && !bad) begin
      unres_nxt = add;
      if (add) begin
        cnt_nxt = cnt_b + 10'd1;
        if (({1'b0, cnt_b} + 11'd1) > (11'(1) << width_b)) begin
          width_nxt = width_b + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 10'(lvwd_pkg::BASE_CODES);
      width_r <= 4'd8;
      buf_r   <= 16'd0;
      bc_r    <= 5'd0;
      unres_r <= 1'b0;
    end else if (accept) begin
      cnt_r   <= cnt_nxt;
      width_r <= width_nxt;
      buf_r   <= buf_nxt;
      bc_r    <= bc_nxt;
      unres_r <= unres_nxt;
    end
  end

endmodule

// ===== hdl/lvwd_queue.sv =====
`timescale 1ns / 1ps
module lvwd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lvwd_pkg::code_item_t push_item,
  input  logic                 pop,
  output lvwd_pkg::q_status_t  q_stat,
  output lvwd_pkg::code_item_t head
);

  lvwd_pkg::code_item_t slot_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign q_stat.full  = fill_r == 2'd2;
  assign q_stat.valid = fill_r != 2'd0;
  assign head         = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    fill_nxt = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== hdl/lvwd_back.sv =====
`timescale 1ns / 1ps
module lvwd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lvwd_pkg::q_status_t  q_stat,
  input  lvwd_pkg::code_item_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_word,
  output logic [3:0]           out_cnt,
  output logic                 out_last,
  output logic                 out_bad
);

  lvwd_pkg::back_state_t state_r, state_nxt;
  lvwd_pkg::code_item_t  item_r, item_nxt;

  logic [8:0]  c_r, c_nxt, sp_r, sp_nxt, rd_ptr_r, rd_ptr_nxt, rem_r, rem_nxt;
  logic [63:0] word_r, word_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt, bad_r, bad_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [63:0] oword_r, oword_nxt;
  logic [3:0]  ocnt_r, ocnt_nxt;
  logic        olast_r, olast_nxt, obad_r, obad_nxt;

  logic [8:0] parent_q;
  logic [7:0] lastc_q, firstc_q, stack_q, first_v, dict_rd_addr, stack_wr_data;
  logic       slot_free;

  assign pop       = (state_r == lvwd_pkg::ST_IDLE) && q_stat.valid;
  assign slot_free = !ovalid_r || out_ready;
  assign first_v   = item_r.code[8] ? firstc_q : item_r.code[7:0];
  // The walk feeds the parent just read straight back as the next address.
  assign dict_rd_addr  = (state_r == lvwd_pkg::ST_WALK) ? parent_q[7:0] : item_r.code[7:0];
  assign stack_wr_data = c_r[8] ? lastc_q : c_r[7:0];

  lvwd_ram #(.WIDTH(9), .DEPTH(256)) u_parent (
    .clk(clk), .wr_en((state_r == lvwd_pkg::ST_RESOLVE) && item_r.add),
    .wr_addr(item_r.new_idx), .wr_data(item_r.code),
    .rd_addr(dict_rd_addr), .rd_data(parent_q)
  );

  lvwd_ram #(.WIDTH(8), .DEPTH(256)) u_lastc (
    .clk(clk), .wr_en((state_r == lvwd_pkg::ST_RESOLVE) && item_r.resolve),
    .wr_addr(item_r.res_idx), .wr_data(first_v),
    .rd_addr(dict_rd_addr), .rd_data(lastc_q)
  );

  lvwd_ram #(.WIDTH(8), .DEPTH(256)) u_firstc (
    .clk(clk), .wr_en((state_r == lvwd_pkg::ST_RESOLVE) && item_r.add),
    .wr_addr(item_r.new_idx), .wr_data(first_v),
    .rd_addr(item_r.code[7:0]), .rd_data(firstc_q)
  );

  lvwd_ram #(.WIDTH(8), .DEPTH(lvwd_pkg::STACK_DEPTH)) u_stack (
    .clk(clk), .wr_en(state_r == lvwd_pkg::ST_WALK),
    .wr_addr(sp_r), .wr_data(stack_wr_data),
    .rd_addr(rd_ptr_r), .rd_data(stack_q)
  );

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    c_nxt      = c_r;
    sp_nxt     = sp_r;
    rd_ptr_nxt = rd_ptr_r;
    rem_nxt    = rem_r;
    word_nxt   = word_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    bad_nxt    = bad_r;
    ovalid_nxt = ovalid_r && !out_ready;
    oword_nxt  = oword_r;
    ocnt_nxt   = ocnt_r;
    olast_nxt  = olast_r;
    obad_nxt   = obad_r;

    unique case (state_r)
      lvwd_pkg::ST_IDLE: begin
        if (q_stat.valid) begin
          item_nxt = head;
          word_nxt = 64'd0;
          cnt_nxt  = 4'd0;
          last_nxt = head.bad;
          bad_nxt  = head.bad;
          state_nxt = head.bad ? lvwd_pkg::ST_EOUT : lvwd_pkg::ST_LOOKUP;
        end
      end
      lvwd_pkg::ST_LOOKUP: state_nxt = lvwd_pkg::ST_RESOLVE;
      lvwd_pkg::ST_RESOLVE: begin
        c_nxt     = item_r.code;
        sp_nxt    = 9'd0;
        state_nxt = lvwd_pkg::ST_WSTART;
      end
      lvwd_pkg::ST_WSTART: state_nxt = lvwd_pkg::ST_WALK;
      lvwd_pkg::ST_WALK: begin
        sp_nxt = sp_r + 9'd1;
        if (c_r[8]) begin
          c_nxt = parent_q;
        end else begin
          // Root byte pushed; read the stack back from the top.
          rd_ptr_nxt = sp_r;
          rem_nxt    = sp_r + 9'd1;
          state_nxt  = lvwd_pkg::ST_EREAD;
        end
      end
      lvwd_pkg::ST_EREAD: state_nxt = lvwd_pkg::ST_ECAP;
      lvwd_pkg::ST_ECAP: begin
        word_nxt   = word_r | ({stack_q, 56'd0} >> {cnt_r, 3'b000});
        cnt_nxt    = cnt_r + 4'd1;
        rem_nxt    = rem_r - 9'd1;
        rd_ptr_nxt = rd_ptr_r - 9'd1;
        if (cnt_r == 4'd7 || rem_r == 9'd1) begin
          last_nxt  = rem_r == 9'd1;
          state_nxt = lvwd_pkg::ST_EOUT;
        end else begin
          state_nxt = lvwd_pkg::ST_EREAD;
        end
      end
      lvwd_pkg::ST_EOUT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          oword_nxt  = word_r;
          ocnt_nxt   = cnt_r;
          olast_nxt  = last_r;
          obad_nxt   = bad_r;
          word_nxt   = 64'd0;
          cnt_nxt    = 4'd0;
          state_nxt  = last_r ? lvwd_pkg::ST_IDLE : lvwd_pkg::ST_EREAD;
        end
      end
      default: state_nxt = lvwd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    c_r      <= c_nxt;
    sp_r     <= sp_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    rem_r    <= rem_nxt;
    word_r   <= word_nxt;
    cnt_r    <= cnt_nxt;
    last_r   <= last_nxt;
    bad_r    <= bad_nxt;
    oword_r  <= oword_nxt;
    ocnt_r   <= ocnt_nxt;
    olast_r  <= olast_nxt;
    obad_r   <= obad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lvwd_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;
  assign out_word  = oword_r;
  assign out_cnt   = ocnt_r;
  assign out_last  = olast_r;
  assign out_bad   = obad_r;

endmodule

// ===== hdl/lzw_variable_width_decoder.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake             | Payload
// in_      | slave     | in_tvalid/in_tready   | in_tdata = compressed byte, in_tuser = new stream
// out_     | master    | out_tvalid/out_tready | out_tdata = bytes and count, tlast, tuser = bad
//
// A byte is taken whenever the two-entry code queue has room; the front end
// unpacks codes and classifies them in the same cycle as the transaction.
// The back end takes a code only when idle; a good code passes lookup, resolve and walk start,
// then the parent walk pushes its string bytes onto the stack, the read-out reads them back
// and each result transaction leaves from the output state; a bad code goes straight there.
// Reset is synchronous and active low; dictionary memories need no clearing.
// A stalled output holds the back end, while the front keeps filling the queue.
module lzw_variable_width_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] compressed_byte
  input  logic        in_tuser,   // [0] new_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] out_bytes, [67:64] byte_count, [71:68] zero
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser   // [0] bad_code
);

  lvwd_pkg::q_status_t  q_stat;
  lvwd_pkg::code_item_t push_item, head;
  logic                 push, pop;
  logic [63:0]          out_word;
  logic [3:0]           out_cnt;

  // Front end: bit unpacking, bad-code check and dictionary bookkeeping.
  lvwd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_byte(in_tdata), .in_new(in_tuser),
    .q_stat(q_stat), .push(push), .push_item(push_item)
  );

  // Short queue that decouples the two halves.
  lvwd_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_item(push_item),
    .pop(pop), .q_stat(q_stat), .head(head)
  );

  // Back end: dictionary update, parent chain walk and result packing.
  lvwd_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_stat(q_stat), .head(head), .pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_word(out_word), .out_cnt(out_cnt),
    .out_last(out_tlast), .out_bad(out_tuser)
  );

  assign out_tdata = {4'd0, out_cnt, out_word};

endmodule

// ===== hdl/lvwd_checker.sv =====
`timescale 1ns / 1ps
`include "lzw_variable_width_decoder_defines.svh"
module lvwd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // A stalled result keeps its payload.
  `LVWD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // A bad code is a single, empty result.
  `LVWD_ASSERT_NOW(a_bad_empty, out_tvalid && out_tuser,
                   out_tlast && (out_tdata == 72'd0))

  // Only the final result of a string may be short.
  `LVWD_ASSERT_NOW(a_full_word, out_tvalid && !out_tlast, out_tdata[67:64] == 4'd8)

  // A good result carries one to eight bytes and zero padding.
  `LVWD_ASSERT_NOW(a_count_range, out_tvalid && !out_tuser,
                   (out_tdata[67:64] != 4'd0) && (out_tdata[67:64] <= 4'd8)
                   && (out_tdata[71:68] == 4'd0))

endmodule

bind lzw_variable_width_decoder lvwd_checker u_lvwd_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int MAX_IDLE = 4000;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
    logic        bad;
  } word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  lzw_variable_width_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Behavioral decoder state.
  logic [8:0]  dict_parent [256];
  logic [7:0]  dict_last   [256];
  logic [7:0]  dict_first  [256];
  int unsigned dict_count;
  int unsigned cur_width;
  logic [19:0] bit_buf;
  int unsigned bit_cnt;
  bit          newest_open;

  word_t pending_words[$];
  int    fail_count;
  int    bytes_sent;
  int    words_seen;
  int    bad_seen;
  int    idle_cycles;

  // Stream packer state.
  int unsigned gen_count;
  logic [31:0] pack_buf;
  int          pack_bits;
  bit          pack_new;

  // Appends one expected word at the tail of the queue.
  function automatic void enqueue_word(word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  // Follows one accepted byte and queues every word that it produces.
  function automatic void decode_byte(logic [7:0] data, logic fresh);
    logic [7:0]  chars[$];
    logic [7:0]  head;
    logic [63:0] acc;
    int unsigned code, c, n, nwords, cnt;
    word_t       w;
    if (fresh) begin
      dict_count = lvwd_pkg::BASE_CODES;
      cur_width = 8;
      bit_buf = '0;
      bit_cnt = 0;
      newest_open = 1'b0;
    end
    bit_buf = {bit_buf[11:0], data};
    bit_cnt += 8;
    if (bit_cnt < cur_width) return;
    bit_cnt -= cur_width;
    code = (bit_buf >> bit_cnt) & ((1 << cur_width) - 1);
    bit_buf &= (20'd1 << bit_cnt) - 20'd1;
    if (code >= dict_count) begin
      w = '{bytes: '0, count: 4'd0, last: 1'b1, bad: 1'b1};
      enqueue_word(w);
      return;
    end
    head = (code < lvwd_pkg::BASE_CODES) ? code[7:0] : dict_first[code - lvwd_pkg::BASE_CODES];
    if (newest_open) begin
      dict_last[dict_count - 1 - lvwd_pkg::BASE_CODES] = head;
      newest_open = 1'b0;
    end
    // The chain yields the string back to front.
    c = code;
    while (c >= lvwd_pkg::BASE_CODES) begin
      chars.push_front(dict_last[c - lvwd_pkg::BASE_CODES]);
      c = dict_parent[c - lvwd_pkg::BASE_CODES];
    end
    chars.push_front(c[7:0]);
    n = chars.size();
    nwords = (n + 7) / 8;
    for (int k = 0; k < nwords; k++) begin
      acc = '0;
      cnt = 0;
      for (int i = 0; i < 8; i++) begin
        if (k * 8 + i < n) begin
          acc[63 - 8 * i -: 8] = chars[k * 8 + i];
          cnt++;
        end
      end
      w = '{bytes: acc, count: cnt[3:0], last: (k + 1 == nwords), bad: 1'b0};
      enqueue_word(w);
    end
    if (dict_count < lvwd_pkg::DICT_ENTRIES) begin
      dict_parent[dict_count - lvwd_pkg::BASE_CODES] = code[8:0];
      dict_first[dict_count - lvwd_pkg::BASE_CODES] = head;
      dict_last[dict_count - lvwd_pkg::BASE_CODES] = '0;
      newest_open = 1'b1;
      dict_count++;
      if (dict_count > (1 << cur_width)) cur_width++;
    end
  endfunction

  // Random gap length: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one byte; called and returning at a falling edge with in_tvalid
  // left high so back-to-back transactions are possible.
  task automatic send_byte(logic [7:0] data, logic fresh);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    in_tuser <= fresh;
    do @(posedge clk); while (!in_tready);
    decode_byte(data, fresh);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic start_stream();
    gen_count = lvwd_pkg::BASE_CODES;
    pack_buf = '0;
    pack_bits = 0;
    pack_new = 1'b1;
  endtask

  // Appends one code at the width the decoder will use for it.
  task automatic push_code(int unsigned code);
    int w;
    w = (gen_count > lvwd_pkg::BASE_CODES) ? 9 : 8;
    pack_buf = (pack_buf << w) | code;
    pack_bits += w;
    while (pack_bits >= 8) begin
      send_byte(8'((pack_buf >> (pack_bits - 8)) & 32'hFF), pack_new);
      pack_new = 1'b0;
      pack_bits -= 8;
    end
    if (code < gen_count && gen_count < lvwd_pkg::DICT_ENTRIES) gen_count++;
  endtask

  // Flushes leftover bits padded with random filler; the filler may or may
  // not finish a further code, which the predictor follows either way.
  task automatic end_stream();
    if (pack_bits > 0) begin
      send_byte(8'((pack_buf << (8 - pack_bits)) | $urandom_range(0, (1 << (8 - pack_bits)) - 1)),
                pack_new);
      pack_bits = 0;
    end
  endtask

  // Mix of literals, the newest entry (string plus its own head byte),
  // older entries and a few out-of-range codes.
  function automatic int unsigned pick_code(int newest_pct);
    int r;
    r = $urandom_range(0, 99);
    if (gen_count == lvwd_pkg::BASE_CODES || r < 20) return $urandom_range(0, 255);
    if (r < 20 + newest_pct) return gen_count - 1;
    if (r < 95 || gen_count >= lvwd_pkg::DICT_ENTRIES) return $urandom_range(0, gen_count - 1);
    return $urandom_range(gen_count, lvwd_pkg::DICT_ENTRIES - 1);
  endfunction

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    start_stream();
    push_code(0);
    push_code(255);
    push_code(256);
    push_code(258);
    push_code(511);
    push_code(259);
    push_code(65);
    push_code(257);
    push_code(0);
    push_code(260);
    end_stream();
    // A lone byte of a fresh stream cannot finish a wider code later on.
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    wait_drain();
  endtask

  // Fills the whole dictionary, mostly through newest-entry references so
  // chains become long, then keeps going once no entries can be added.
  task automatic test_full_dictionary();
    start_stream();
    while (gen_count < lvwd_pkg::DICT_ENTRIES) push_code(pick_code(70));
    push_code(lvwd_pkg::DICT_ENTRIES - 1);
    repeat (4) push_code(pick_code(30));
    end_stream();
    wait_drain();
  endtask

  task automatic test_random_streams();
    int len;
    repeat (6) begin
      start_stream();
      len = $urandom_range(3, 12);
      repeat (len) push_code(pick_code(30));
      end_stream();
      if ($urandom_range(0, 2) == 0) wait_drain();
    end
    wait_drain();
  endtask

  // Raw bytes with random stream starts: mostly bad or short codes.
  task automatic test_noise();
    repeat (20) send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 4) == 0));
    wait_drain();
  endtask

  // Result side: random stalls, sampled and checked at the rising edge.
  int stall_left;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    word_t got, want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_tvalid && out_tready) begin
        words_seen++;
        got = '{bytes: out_tdata[63:0], count: out_tdata[67:64], last: out_tlast,
                bad: out_tuser};
        if (out_tuser) bad_seen++;
        if (pending_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result transaction: %h", got);
        end else begin
          want = pending_words.pop_front();
          if (got !== want || out_tdata[71:68] !== 4'd0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch: bytes %h/%h count %0d/%0d last %b/%b bad %b/%b (exp/act)",
                       want.bytes, got.bytes, want.count, got.count, want.last, got.last,
                       want.bad, got.bad);
          end
        end
      end
      if (idle_cycles >= MAX_IDLE) begin
        $display("Timeout with %0d results outstanding", pending_words.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    stall_left = 0;
    fail_count = 0;
    bytes_sent = 0;
    words_seen = 0;
    bad_seen = 0;
    idle_cycles = 0;
    dict_count = lvwd_pkg::BASE_CODES;
    cur_width = 8;
    bit_buf = '0;
    bit_cnt = 0;
    newest_open = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_full_dictionary();
    test_random_streams();
    test_noise();
    wait_drain();
    $display("Sent %0d compressed bytes; checked %0d result words (%0d bad codes),",
             bytes_sent, words_seen, bad_seen);
    $display("including a full dictionary and long newest-entry chains.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== lzw_variable_width_decoder.f =====
+incdir+hdl
hdl/lvwd_pkg.sv
hdl/lvwd_ram.sv
hdl/lvwd_front.sv
hdl/lvwd_queue.sv
hdl/lvwd_back.sv
hdl/lzw_variable_width_decoder.sv
hdl/lvwd_checker.sv
sim/tb.sv
